/* rtl/fpt_pkg.sv */
package fpt_pkg;

    localparam int KIND_W  = 2;
    localparam int STAMP_W = 48;
    localparam int RATE_W  = 10;
    localparam int IV_W    = 20;

    localparam int MICROS_PER_SEC = 1000000;
    localparam int RESET_FPS      = 60;

    localparam logic [IV_W-1:0] DIVIDEND       = IV_W'(MICROS_PER_SEC);
    localparam logic [IV_W-1:0] RESET_INTERVAL = IV_W'(MICROS_PER_SEC / RESET_FPS);

    typedef enum logic [KIND_W-1:0] {
        KIND_START = 2'd0,
        KIND_STOP  = 2'd1,
        KIND_POLL  = 2'd2,
        KIND_QUERY = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_DIV,
        ST_CMP,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic ready;
        logic calc;
        logic div_start;
        logic cmp;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic  req_valid;
        kind_t kind;
        logic  active;
        logic  div_done;
        logic  out_busy;
    } ctrl_sts_t;

endpackage

/* rtl/fpt_req_if.sv */
interface fpt_req_if import fpt_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [STAMP_W-1:0]  now_us;
    logic [RATE_W-1:0]   rate_fps;

    modport source (output valid, output kind, output now_us, output rate_fps, input ready);
    modport sink   (input valid, input kind, input now_us, input rate_fps, output ready);
endinterface

/* rtl/fpt_rsp_if.sv */
interface fpt_rsp_if import fpt_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                accepted;
    logic                frame_due;
    logic                running;
    logic [STAMP_W-1:0]  stamp_us;

    modport source (output valid, output accepted, output frame_due, output running,
                    output stamp_us, input ready);
    modport sink   (input valid, input accepted, input frame_due, input running,
                    input stamp_us, output ready);
endinterface

/* rtl/fpt_div.sv */
// Restoring divider: fixed dividend of one second in microseconds, one quotient bit a cycle.
module fpt_div import fpt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [RATE_W-1:0] divisor,
    output logic              done,
    output logic [IV_W-1:0]   quotient
);

    localparam int CNT_W = $clog2(IV_W);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [RATE_W-1:0] rem_reg;
    logic [RATE_W-1:0] dvs_reg;
    logic [IV_W-1:0]   quo_reg;

    logic [RATE_W:0]   rem_sh;
    logic [RATE_W:0]   rem_dif;
    logic              fits;

    assign rem_sh  = {rem_reg, quo_reg[IV_W-1]};
    assign fits    = rem_sh >= {1'b0, dvs_reg};
    assign rem_dif = rem_sh - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(IV_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            // a zero rate divides as rate one
            dvs_reg <= (divisor == '0) ? RATE_W'(1) : divisor;
            rem_reg <= '0;
            quo_reg <= DIVIDEND;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? rem_dif[RATE_W-1:0] : rem_sh[RATE_W-1:0];
            quo_reg <= {quo_reg[IV_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* rtl/fpt_dp.sv */
module fpt_dp import fpt_pkg::*;
#(
    parameter int TIME_BITS = 48
)
(
    input  logic       clk,
    input  logic       rst_n,
    fpt_req_if.sink    req,
    fpt_rsp_if.source  rsp,
    input  ctrl_cmd_t  cmd,
    output ctrl_sts_t  sts
);

    logic                 active_reg, active_next;
    logic                 first_reg, first_next;
    logic [IV_W-1:0]      interval_reg, interval_next;
    logic [TIME_BITS-1:0] last_reg, last_next;
    logic [TIME_BITS-1:0] start_reg, start_next;

    kind_t                kind_reg;
    logic [TIME_BITS-1:0] now_reg;
    logic [RATE_W-1:0]    rate_reg;
    logic [TIME_BITS-1:0] elapsed_reg;
    logic [TIME_BITS-1:0] stamp_reg;
    logic [TIME_BITS-1:0] adv_reg;
    logic                 lt_reg;
    logic                 gt_reg;

    logic                 out_valid_reg;
    logic                 out_accepted_reg;
    logic                 out_due_reg;
    logic                 out_running_reg;
    logic [STAMP_W-1:0]   out_stamp_reg;

    logic                 acc_c;
    logic                 due_c;
    logic                 div_done;
    logic [IV_W-1:0]      div_quo;
    logic                 req_fire;

    assign req_fire  = req.valid && req.ready;
    assign req.ready = cmd.ready;

    fpt_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .divisor  (rate_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb
    begin
        active_next   = active_reg;
        first_next    = first_reg;
        interval_next = interval_reg;
        last_next     = last_reg;
        start_next    = start_reg;
        acc_c         = 1'b0;
        due_c         = 1'b0;
        unique case (kind_reg)
            KIND_START:
            begin
                if (!active_reg)
                begin
                    interval_next = div_quo;
                    active_next   = 1'b1;
                    acc_c         = 1'b1;
                end
            end
            KIND_STOP:
            begin
                if (active_reg)
                begin
                    active_next = 1'b0;
                    acc_c       = 1'b1;
                end
            end
            KIND_POLL:
            begin
                if (!active_reg)
                    first_next = 1'b1;
                else if (first_reg)
                begin
                    // first active poll since reset or since a poll while inactive only sets the marks
                    first_next = 1'b0;
                    start_next = now_reg;
                    last_next  = now_reg;
                end
                else if (!lt_reg)
                begin
                    due_c     = 1'b1;
                    // catch up: jump to now when more than two intervals behind
                    last_next = gt_reg ? now_reg : adv_reg;
                end
            end
            KIND_QUERY:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            first_reg     <= 1'b1;
            interval_reg  <= RESET_INTERVAL;
            last_reg      <= '0;
            start_reg     <= '0;
            kind_reg      <= KIND_QUERY;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_fire)
                kind_reg <= kind_t'(req.kind);
            if (cmd.commit)
            begin
                active_reg   <= active_next;
                first_reg    <= first_next;
                interval_reg <= interval_next;
                last_reg     <= last_next;
                start_reg    <= start_next;
            end
            if (cmd.commit)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            now_reg  <= TIME_BITS'(req.now_us);
            rate_reg <= req.rate_fps;
        end
        if (cmd.calc)
        begin
            elapsed_reg <= now_reg - last_reg;
            stamp_reg   <= now_reg - start_reg;
        end
        if (cmd.cmp)
        begin
            lt_reg  <= elapsed_reg < TIME_BITS'(interval_reg);
            gt_reg  <= elapsed_reg > TIME_BITS'({interval_reg, 1'b0});
            adv_reg <= last_reg + TIME_BITS'(interval_reg);
        end
        if (cmd.commit)
        begin
            out_accepted_reg <= acc_c;
            out_due_reg      <= due_c;
            out_running_reg  <= active_next;
            out_stamp_reg    <= (kind_reg == KIND_QUERY) ? STAMP_W'(stamp_reg) : '0;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.accepted  = out_accepted_reg;
    assign rsp.frame_due = out_due_reg;
    assign rsp.running   = out_running_reg;
    assign rsp.stamp_us  = out_stamp_reg;

    assign sts.req_valid = req.valid;
    assign sts.kind      = kind_reg;
    assign sts.active    = active_reg;
    assign sts.div_done  = div_done;
    assign sts.out_busy  = out_valid_reg && !rsp.ready;

`ifndef NO_ASSERTIONS
    a_commit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !(out_valid_reg && !rsp.ready))
        else $error("result committed over a pending transaction");

    a_due_moves_mark: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && due_c) |=> last_reg != $past(last_reg))
        else $error("frame due without advancing the last mark");

    a_rise_by_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(active_reg) |-> $past(cmd.commit && kind_reg == KIND_START))
        else $error("capture became active without a start");

    a_first_only_active: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(first_reg) |-> $past(active_reg && kind_reg == KIND_POLL))
        else $error("first-frame flag cleared outside an active poll");
`endif

endmodule

/* rtl/fpt_ctrl.sv */
module fpt_ctrl import fpt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  ctrl_sts_t  sts,
    output ctrl_cmd_t  cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.ready = 1'b1;
                if (sts.req_valid)
                    state_next = ST_DECODE;
            end
            ST_DECODE:
            begin
                cmd.calc = 1'b1;
                if (sts.kind == KIND_START && !sts.active)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
                else
                    state_next = ST_CMP;
            end
            ST_DIV:
            begin
                if (sts.div_done)
                    state_next = ST_FIN;
            end
            ST_CMP:
            begin
                cmd.cmp    = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!sts.out_busy)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule

/* rtl/frame_pacing_timer_core.sv */
// Frame pacing timer. Each request transaction (start, stop, poll, timestamp query) yields
// exactly one response transaction. Requests are handled one at a time: poll, query, stop
// and refused starts go through decode, compare and finish before the next request is
// taken; an accepted start goes through decode, divide and finish, waiting in divide for
// the bit-serial divider forming the frame interval (1000000 / rate) one quotient bit per
// cycle. A finished response sits in an output register, so the block can take the next
// request while the previous one is still waiting; it stalls only when a second response
// is ready and the first has not been taken. Time differences wrap at TIME_BITS bits.
module frame_pacing_timer_core import fpt_pkg::*;
#(
    parameter int TIME_BITS = 48
)
(
    input  logic       clk,
    input  logic       rst_n,
    fpt_req_if.sink    req,
    fpt_rsp_if.source  rsp
);

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    fpt_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    fpt_dp #(
        .TIME_BITS (TIME_BITS)
    ) u_dp
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cmd   (cmd),
        .sts   (sts)
    );

endmodule
